>>> rtl/fdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types, register indexes, reset values and helpers of the feedback
// delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

  localparam int SampleW = 16;
  localparam int LenCfgW = 18;
  localparam int GainW   = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 18;
  localparam int AccW    = 34;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic        [GainW-1:0]   gain_t;
  typedef logic signed [AccW-1:0]    acc_t;

  // register indexes of the config port
  localparam logic [CfgIdxW-1:0] REG_DELAY_LENGTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FEEDBACK_GAIN = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WET_MIX       = 2'd2;

  localparam logic [LenCfgW-1:0] DELAY_LENGTH_RST  = 18'd48510;
  localparam gain_t              FEEDBACK_GAIN_RST = 16'd16384;
  localparam gain_t              WET_MIX_RST       = 16'd16384;

  // Q1.15 unity
  localparam gain_t UNITY = 16'd32768;

  // output buffer behind the arithmetic pipe
  localparam int OutFifoDepth = 8;
  localparam int OutFifoAw    = $clog2(OutFifoDepth);

  function automatic sample_t sat16(acc_t v);
    sample_t r;
    if (v > acc_t'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -acc_t'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

  function automatic gain_t gain_clip(gain_t g);
    gain_t r;
    r = (g > UNITY) ? UNITY : g;
    return r;
  endfunction

endpackage

>>> rtl/feedback_delay_line_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_delay_line_top
// Feedback echo on a circular delay RAM: read-modify-write of the entry at
// the write pointer, wet/dry mix of the entry one ahead, saturated output.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                                  Content
// s_axis    in   s_axis_tvalid/tready, tdata[15:0]        in_sample
// m_axis    out  m_axis_tvalid/tready, tdata[15:0]        out_sample
// cfg       in   cfg_valid_i/ready_o, cfg_index_i, data   register writes
//
// One sample per cycle unless the input is held off; the result passes the
// 4-stage pipe behind the RAM read (feedback multiply, round and
// write back, mix multiply, dry add and round) into the output FIFO.
// For delay lengths of 1 to 3 the input stalls until the RAM write of a
// sample still in flight has landed.
// Reset clears pointer, fill count and pipe; RAM entries past the fill
// count read as zero, so no clearing pass is needed. An 8-entry output FIFO
// absorbs output stalls; input is held off once pipe plus FIFO are full.
// ----------------------------------------------------------------------------
module feedback_delay_line_top #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] in_sample
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [15:0] out_sample
  // config writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fdl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fdl_pkg::CfgDatW-1:0]   cfg_data_i
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int LW = AW + 1;
  localparam int CW = (LW > fdl_pkg::LenCfgW) ? LW : fdl_pkg::LenCfgW;
  localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
  localparam int FA = fdl_pkg::OutFifoAw;
  localparam int FD = fdl_pkg::OutFifoDepth;

  // ---------------- config registers ----------------
  logic [fdl_pkg::LenCfgW-1:0] len_cfg_q;
  fdl_pkg::gain_t              fb_cfg_q, mix_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= fdl_pkg::DELAY_LENGTH_RST;
      fb_cfg_q  <= fdl_pkg::FEEDBACK_GAIN_RST;
      mix_cfg_q <= fdl_pkg::WET_MIX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fdl_pkg::REG_DELAY_LENGTH:  len_cfg_q <= cfg_data_i;
        fdl_pkg::REG_FEEDBACK_GAIN: fb_cfg_q  <= cfg_data_i[fdl_pkg::GainW-1:0];
        fdl_pkg::REG_WET_MIX:       mix_cfg_q <= cfg_data_i[fdl_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] len_ext;
  logic [LW-1:0] eff_len;
  fdl_pkg::gain_t fb_gain, mix_gain;

  always_comb begin
    len_ext = CW'(len_cfg_q);
    if (len_ext == '0) begin
      eff_len = LW'(1);
    end else if (len_ext > DEPTH_C) begin
      eff_len = LW'(DEPTH_C);
    end else begin
      eff_len = LW'(len_ext);
    end
  end

  assign fb_gain  = fdl_pkg::gain_clip(fb_cfg_q);
  assign mix_gain = fdl_pkg::gain_clip(mix_cfg_q);

  // ---------------- pointer and read addresses ----------------
  logic [AW-1:0] ptr_q;
  logic [AW-1:0] rd_old_addr, rd_ent_addr;
  logic [LW-1:0] p_ext, p1_ext;

  always_comb begin
    p_ext = (LW'(ptr_q) >= eff_len) ? '0 : LW'(ptr_q);
    p1_ext = p_ext + LW'(1);
    if (p1_ext >= eff_len) begin
      p1_ext = '0;
    end
    rd_old_addr = p_ext[AW-1:0];
    rd_ent_addr = p1_ext[AW-1:0];
  end

  // ---------------- pipe control ----------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [AW-1:0] s1_addr_q, s2_addr_q;
  logic [FA:0] fifo_cnt_q;
  logic [FA:0] inflight;
  logic hazard, in_xfer, out_xfer;

  // a read would miss a write still in the pipe: hold the input
  assign hazard = (s1_v_q && (rd_old_addr == s1_addr_q || rd_ent_addr == s1_addr_q)) ||
                  (s2_v_q && (rd_old_addr == s2_addr_q || rd_ent_addr == s2_addr_q));

  assign inflight = (FA+1)'(s1_v_q) + (FA+1)'(s2_v_q) + (FA+1)'(s3_v_q) + (FA+1)'(s4_v_q);
  assign s_axis_tready = !hazard && ((fifo_cnt_q + inflight) < (FA+1)'(FD));
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // ---------------- delay RAM ----------------
  fdl_pkg::sample_t dly_mem [DELAY_DEPTH];
  fdl_pkg::sample_t old_raw_q, ent_raw_q;
  fdl_pkg::sample_t new_d;
  logic [LW-1:0] fill_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      old_raw_q <= dly_mem[rd_old_addr];
      ent_raw_q <= dly_mem[rd_ent_addr];
    end
    if (s2_v_q) begin
      dly_mem[s2_addr_q] <= new_d;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        ptr_q <= rd_ent_addr;
      end
      // writes go in pointer order from zero, so the written set is a prefix
      if (s2_v_q && LW'(s2_addr_q) == fill_q) begin
        fill_q <= fill_q + LW'(1);
      end
      s1_v_q <= in_xfer;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  // ---------------- stage 1: feedback multiply ----------------
  fdl_pkg::sample_t s1_x_q;
  logic s1_old_ok_q, s1_ent_ok_q, s1_len1_q;
  fdl_pkg::sample_t s1_old, s1_ent;
  logic signed [17:0] s1_op;
  fdl_pkg::acc_t s1_prod;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_x_q      <= s_axis_tdata;
      s1_addr_q   <= rd_old_addr;
      s1_old_ok_q <= (p_ext < fill_q);
      s1_ent_ok_q <= (p1_ext < fill_q);
      s1_len1_q   <= (eff_len == LW'(1));
    end
  end

  always_comb begin
    s1_old  = s1_old_ok_q ? old_raw_q : '0;
    s1_ent  = s1_ent_ok_q ? ent_raw_q : '0;
    s1_op   = (18'(s1_old) <<< 1) + 18'(s1_x_q);
    s1_prod = fdl_pkg::AccW'(s1_op) * fdl_pkg::AccW'($signed({1'b0, fb_gain}));
  end

  // ---------------- stage 2: round, saturate, write back ----------------
  fdl_pkg::acc_t    s2_prod_q;
  fdl_pkg::sample_t s2_x_q, s2_ent_q;
  logic             s2_len1_q;

  always_ff @(posedge clk_i) begin
    s2_prod_q <= s1_prod;
    s2_x_q    <= s1_x_q;
    s2_ent_q  <= s1_ent;
    s2_len1_q <= s1_len1_q;
    s2_addr_q <= s1_addr_q;
  end

  assign new_d = fdl_pkg::sat16((s2_prod_q + fdl_pkg::acc_t'(32768)) >>> 16);

  // ---------------- stage 3: mix multiply ----------------
  fdl_pkg::sample_t s3_x_q, s3_ent_q, s3_new_q, s3_tap;
  logic             s3_len1_q;
  logic signed [16:0] s3_diff;
  fdl_pkg::acc_t    s3_prod;

  always_ff @(posedge clk_i) begin
    s3_x_q    <= s2_x_q;
    s3_ent_q  <= s2_ent_q;
    s3_new_q  <= new_d;
    s3_len1_q <= s2_len1_q;
  end

  // entry*mix + x*(1-mix) == mix*(entry-x) + x
  always_comb begin
    s3_tap  = s3_len1_q ? s3_new_q : s3_ent_q;
    s3_diff = 17'(s3_tap) - 17'(s3_x_q);
    s3_prod = fdl_pkg::AccW'(s3_diff) * fdl_pkg::AccW'($signed({1'b0, mix_gain}));
  end

  // ---------------- stage 4: dry add, round, saturate ----------------
  fdl_pkg::acc_t    s4_prod_q, s4_acc;
  fdl_pkg::sample_t s4_x_q, s4_y;

  always_ff @(posedge clk_i) begin
    s4_prod_q <= s3_prod;
    s4_x_q    <= s3_x_q;
  end

  always_comb begin
    s4_acc = s4_prod_q + (fdl_pkg::AccW'(s4_x_q) <<< 15);
    s4_y   = fdl_pkg::sat16((s4_acc + fdl_pkg::acc_t'(16384)) >>> 15);
  end

  // ---------------- output FIFO ----------------
  fdl_pkg::sample_t fifo_mem [FD];
  logic [FA-1:0] fifo_wr_q, fifo_rd_q;

  always_ff @(posedge clk_i) begin
    if (s4_v_q) begin
      fifo_mem[fifo_wr_q] <= s4_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wr_q  <= '0;
      fifo_rd_q  <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (s4_v_q) begin
        fifo_wr_q <= fifo_wr_q + FA'(1);
      end
      if (out_xfer) begin
        fifo_rd_q <= fifo_rd_q + FA'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + (FA+1)'(s4_v_q) - (FA+1)'(out_xfer);
    end
  end

  assign m_axis_tdata = fifo_mem[fifo_rd_q];

endmodule

>>> tb/tb_feedback_delay_line_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_feedback_delay_line_top
// Self-checking bench for the feedback delay echo. A bit-accurate echo model
// (ring store, pointer, gains) runs on every accepted input sample and
// queues the expected output sample. Each output transfer is checked against
// the oldest queued value. Directed cases cover the field extremes, the
// delay length and gain limits and pointer restart. Random traffic then
// runs under four idle/stall mixes, with register changes between segments.
// ----------------------------------------------------------------------------
module tb_feedback_delay_line_top;
  import fdl_pkg::*;

  localparam int EchoDepth     = 131072;
  localparam int WatchdogLimit = 2000;
  localparam int MaxPrinted    = 100;
  // index outside the register map, must be ignored
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata  = '0;   // [15:0] in_sample
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;         // [15:0] out_sample
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [CfgDatW-1:0] cfg_data_i    = '0;

  feedback_delay_line_top #(
    .DELAY_DEPTH(EchoDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // echo model state
  sample_t              echo_mem [EchoDepth];
  int unsigned          echo_wr_ptr;
  logic [LenCfgW-1:0]   cfg_len = DELAY_LENGTH_RST;
  gain_t                cfg_fb  = FEEDBACK_GAIN_RST;
  gain_t                cfg_mix = WET_MIX_RST;

  sample_t     echo_expect_q [$];
  int unsigned fail_count     = 0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int          quiet_cycles   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic sample_t clamp16(input longint v);
    sample_t r;
    if (v > 32767) begin
      r = 16'sh7fff;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // one sample through the echo: rewrite entry at pointer, advance, mix
  function automatic sample_t echo_predict(input sample_t x);
    longint unsigned len;
    longint          fb;
    longint          mix;
    longint          xs;
    longint          acc;
    longint          entry;
    if (cfg_len == '0) begin
      len = 1;
    end else if (cfg_len > EchoDepth) begin
      len = EchoDepth;
    end else begin
      len = cfg_len;
    end
    fb  = (cfg_fb > UNITY) ? longint'(UNITY) : longint'(cfg_fb);
    mix = (cfg_mix > UNITY) ? longint'(UNITY) : longint'(cfg_mix);
    xs  = longint'(x);
    if (echo_wr_ptr >= len) echo_wr_ptr = 0;
    entry = longint'(echo_mem[echo_wr_ptr]);
    acc   = 2 * entry * fb + xs * fb;
    echo_mem[echo_wr_ptr] = clamp16((acc + 32768) >>> 16);
    echo_wr_ptr++;
    if (echo_wr_ptr >= len) echo_wr_ptr = 0;
    entry = longint'(echo_mem[echo_wr_ptr]);
    acc   = entry * mix + xs * (32768 - mix);
    return clamp16((acc + 16384) >>> 15);
  endfunction

  task automatic report_mismatch(input string what, input sample_t exp_s,
                                 input sample_t got_s);
    fail_count++;
    if (fail_count <= MaxPrinted) begin
      $display("[%0t] %s: out_sample expected %0d got %0d", $time, what, exp_s, got_s);
    end
  endtask

  // output checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (echo_expect_q.size() == 0) begin
        report_mismatch("unexpected transfer", '0, m_axis_tdata);
      end else begin
        if (m_axis_tdata !== echo_expect_q[0]) begin
          report_mismatch("mismatch", echo_expect_q[0], m_axis_tdata);
        end
        void'(echo_expect_q.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("** feedback_delay_line_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // entered and left at a falling edge
  task automatic send_sample(input sample_t x);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = x;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    echo_expect_q.push_back(echo_predict(x));
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid = 1'b0;
    while (echo_expect_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // only while idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_DELAY_LENGTH:  cfg_len = val[LenCfgW-1:0];
      REG_FEEDBACK_GAIN: cfg_fb  = val[GainW-1:0];
      REG_WET_MIX:       cfg_mix = val[GainW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(7))
      0:       s = 16'sh7fff;
      1:       s = 16'sh8000;
      2:       s = sample_t'($urandom_range(0, 255)) - 16'sd128;
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  function automatic logic [CfgDatW-1:0] rand_gain();
    logic [CfgDatW-1:0] g;
    case ($urandom_range(9))
      8:       g = CfgDatW'(UNITY);
      9:       g = CfgDatW'($urandom_range(32769, 65535));
      default: g = CfgDatW'($urandom_range(0, 32768));
    endcase
    return g;
  endfunction

  function automatic logic [CfgDatW-1:0] rand_length();
    logic [CfgDatW-1:0] l;
    case ($urandom_range(9))
      0:       l = CfgDatW'($urandom_range(1, 3));
      7:       l = CfgDatW'($urandom_range(65, 1024));
      8:       l = '0;
      9:       l = CfgDatW'($urandom_range(0, 262143));
      default: l = CfgDatW'($urandom_range(4, 64));
    endcase
    return l;
  endfunction

  task automatic test_reset_defaults();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
  endtask

  task automatic test_short_delays();
    wait_drain();
    write_reg(REG_DELAY_LENGTH, 18'd1);  // reads back the entry just written
    write_reg(REG_FEEDBACK_GAIN, CfgDatW'(UNITY));
    write_reg(REG_WET_MIX, CfgDatW'(UNITY));
    send_sample(16'sh7fff);
    send_sample(16'sh4000);
    send_sample(16'sh8000);
    wait_drain();
    write_reg(REG_DELAY_LENGTH, 18'd0);  // behaves as length one
    send_sample(16'sh1234);
    send_sample(-16'sd300);
    wait_drain();
    write_reg(REG_DELAY_LENGTH, 18'd3);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    wait_drain();
  endtask

  task automatic test_gain_limits();
    write_reg(REG_DELAY_LENGTH, 18'd2);
    write_reg(REG_FEEDBACK_GAIN, 18'd0);
    write_reg(REG_WET_MIX, 18'd0);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    wait_drain();
    // gains above unity clip to 1.0
    write_reg(REG_FEEDBACK_GAIN, 18'h0ffff);
    write_reg(REG_WET_MIX, 18'h0ffff);
    write_reg(REG_UNUSED, 18'h3ffff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    wait_drain();
  endtask

  task automatic test_pointer_restart();
    write_reg(REG_FEEDBACK_GAIN, 18'd24576);
    write_reg(REG_WET_MIX, 18'd8192);
    write_reg(REG_DELAY_LENGTH, 18'd8);
    while (echo_wr_ptr < 6) send_sample(rand_sample());
    wait_drain();
    // pointer now past the shorter ring
    write_reg(REG_DELAY_LENGTH, 18'd3);
    send_sample(16'sh2000);
    send_sample(-16'sd2000);
    wait_drain();
  endtask

  task automatic test_long_delays();
    write_reg(REG_DELAY_LENGTH, CfgDatW'(EchoDepth));
    send_sample(16'sh7fff);
    wait_drain();
    write_reg(REG_DELAY_LENGTH, 18'h3ffff);  // above the store depth
    send_sample(16'sh8000);
    wait_drain();
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int n_items);
    int sent;
    int seg;
    int k;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_drain();
      if ($urandom_range(2) != 0) write_reg(REG_DELAY_LENGTH, rand_length());
      if ($urandom_range(2) != 0) write_reg(REG_FEEDBACK_GAIN, rand_gain());
      if ($urandom_range(2) != 0) write_reg(REG_WET_MIX, rand_gain());
      seg = $urandom_range(20, 100);
      for (k = 0; k < seg; k++) begin
        // sender holds off until the output side has caught up
        if ($urandom_range(39) == 0) wait_drain();
        send_sample(rand_sample());
      end
      sent += seg;
    end
    wait_drain();
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 290);
    run_phase(53, 0, 290);
    run_phase(0, 53, 290);
    run_phase(25, 25, 290);
  endtask

  initial begin
    foreach (echo_mem[i]) echo_mem[i] = '0;
    echo_wr_ptr = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_short_delays();
    test_gain_limits();
    test_pointer_restart();
    test_long_delays();
    test_random_traffic();

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (echo_expect_q.size() != 0) begin
      report_mismatch("missing transfer", echo_expect_q[0], '0);
    end
    if (fail_count == 0) begin
      $display("** feedback_delay_line_top: PASSED **");
    end else begin
      $display("** feedback_delay_line_top: FAILED **");
    end
    $finish;
  end

endmodule
